/* design/barometric_sensor_compensation_core_macros.svh */
// Assertion macros for the barometric compensation core.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_CORE_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define BSC_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// A condition that must hold in the cycle after a trigger.
`define BSC_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("assertion failed");

`endif

/* design/bsc_pkg.sv */
// Shared constants, register indexes and a helper function for the
// barometric compensation core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

	// Divider word width and pipeline depth (one quotient bit per stage).
	localparam int DIV_W   = 32;
	localparam int DIV_LAT = DIV_W;

	// Configuration register indexes.
	localparam logic [1:0] REG_CAL_A = 2'd0;
	localparam logic [1:0] REG_CAL_B = 2'd1;
	localparam logic [1:0] REG_CAL_C = 2'd2;
	localparam logic [1:0] REG_OSS   = 2'd3;

	// Compensation constants.
	localparam logic signed [31:0] T_OFFSET  = 32'sd4000;
	localparam logic signed [31:0] X_OFFSET  = 32'sd32768;
	localparam logic        [15:0] P_SCALE   = 16'd50000;
	localparam logic signed [15:0] P_COEF_A  = 16'sd3038;
	localparam logic signed [15:0] P_COEF_B  = -16'sd7357;
	localparam logic signed [31:0] P_COEF_C  = 32'sd3791;

	// Signed division by 2**sh that truncates toward zero.
	function automatic logic signed [31:0] tdiv(input logic signed [31:0] v,
		input logic [4:0] sh);
		logic signed [31:0] bias;
		bias = v[31] ? signed'((32'd1 << sh) - 32'd1) : 32'sd0;
		return (v + bias) >>> sh;
	endfunction

endpackage

`default_nettype wire

/* design/bsc_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on bsc_pkg for the word width and depth.
`timescale 1ns / 1ps
`default_nettype none

module bsc_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_vld,
	input  wire logic [bsc_pkg::DIV_W-1:0] num,
	input  wire logic [bsc_pkg::DIV_W-1:0] den,
	output logic                           out_vld,
	output logic      [bsc_pkg::DIV_W-1:0] quo
);
	import bsc_pkg::*;

	logic [DIV_W-1:0] rem_s [DIV_LAT];
	logic [DIV_W-1:0] quo_s [DIV_LAT];
	logic [DIV_W-1:0] den_s [DIV_LAT];
	logic             vld_s [DIV_LAT];

	logic [DIV_W-1:0] rem_n [DIV_LAT];
	logic [DIV_W-1:0] quo_n [DIV_LAT];

	always_comb begin : step
		logic [DIV_W-1:0] r_in;
		logic [DIV_W-1:0] q_in;
		logic [DIV_W-1:0] d_in;
		logic [DIV_W:0]   trial;
		for (int k = 0; k < DIV_LAT; k++) begin
			if (k == 0) begin
				r_in = '0;
				q_in = num;
				d_in = den;
			end else begin
				r_in = rem_s[k-1];
				q_in = quo_s[k-1];
				d_in = den_s[k-1];
			end
			// The dividend shifts out of the top of q_in as quotient bits come in.
			trial = {r_in, q_in[DIV_W-1]};
			if (trial >= {1'b0, d_in}) begin
				rem_n[k] = DIV_W'(trial - {1'b0, d_in});
				quo_n[k] = {q_in[DIV_W-2:0], 1'b1};
			end else begin
				rem_n[k] = trial[DIV_W-1:0];
				quo_n[k] = {q_in[DIV_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int k = 1; k < DIV_LAT; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_LAT; k++) begin
				rem_s[k] <= rem_n[k];
				quo_s[k] <= quo_n[k];
			end
			den_s[0] <= den;
			for (int k = 1; k < DIV_LAT; k++) den_s[k] <= den_s[k-1];
		end
	end

	assign out_vld = vld_s[DIV_LAT-1];
	assign quo     = quo_s[DIV_LAT-1];

endmodule

`default_nettype wire

/* design/barometric_sensor_compensation_core.sv */
// Top level of the barometric compensation core: configuration registers,
// arithmetic stages and two dividers. Depends on bsc_pkg, bsc_div and the macros header.
//
//   channel   signals                                    direction
//   input     in_valid, in_stall, raw_temperature,       in, stall out
//             raw_pressure
//   output    out_valid, out_stall, temperature_tenths,  out, stall in
//             pressure_pa, divide_error
//   config    cfg_write, cfg_index, cfg_data             in
//
// One item enters per cycle while in_stall is low; there are 15 arithmetic stages plus
// two 32-stage dividers that produce one quotient bit per stage.
// All stages advance together; while a result waits under out_stall the whole
// pipeline holds and in_stall is raised. Reset clears the valid bits and the
// configuration registers; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "barometric_sensor_compensation_core_macros.svh"

module barometric_sensor_compensation_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [63:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [15:0]        raw_temperature,
	input  wire logic [18:0]        raw_pressure,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      temperature_tenths,
	output logic [19:0]             pressure_pa,
	output logic                    divide_error
);
	import bsc_pkg::*;

	typedef struct packed {
		logic               vld;
		logic signed [31:0] x1;
		logic               neg;
		logic               dz;
		logic [18:0]        up;
	} tline_t;

	typedef struct packed {
		logic               vld;
		logic signed [15:0] temp;
		logic               err;
		logic               pre;
	} pline_t;

	logic [63:0] cal_a_q, cal_b_q;
	logic [31:0] cal_c_q;
	logic [1:0]  oss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
			oss_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_CAL_A: cal_a_q <= cfg_data;
				REG_CAL_B: cal_b_q <= cfg_data;
				REG_CAL_C: cal_c_q <= cfg_data[31:0];
				REG_OSS:   oss_q   <= cfg_data[1:0];
			endcase
		end
	end

	logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [15:0]        ac4, ac5, ac6;
	assign ac1 = signed'(cal_a_q[15:0]);
	assign ac2 = signed'(cal_a_q[31:16]);
	assign ac3 = signed'(cal_a_q[47:32]);
	assign ac4 = cal_a_q[63:48];
	assign ac5 = cal_b_q[15:0];
	assign ac6 = cal_b_q[31:16];
	assign b1  = signed'(cal_b_q[47:32]);
	assign b2  = signed'(cal_b_q[63:48]);
	assign mc  = signed'(cal_c_q[15:0]);
	assign md  = signed'(cal_c_q[31:16]);

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Valid bits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, v_s14;
	logic dv1, dv2;
	logic [31:0] dq1, dq2;

	// Stage 1: (ut - ac6) * ac5.
	logic signed [16:0] t0, ac5x;
	logic signed [33:0] p1;
	logic signed [31:0] p1_s1;
	logic [18:0]        up_s1;
	assign t0   = signed'({1'b0, raw_temperature}) - signed'({1'b0, ac6});
	assign ac5x = signed'({1'b0, ac5});
	assign p1   = 34'(t0) * 34'(ac5x);

	// Stage 2: x1, divisor and magnitudes for the temperature divider.
	logic signed [31:0] x1t, dt, n32;
	logic signed [31:0] x1_s2;
	logic [31:0]        nmag_s2, dmag_s2;
	logic               neg_s2, dz_s2;
	logic [18:0]        up_s2;
	assign x1t = tdiv(p1_s1, 5'd15);
	assign dt  = x1t + 32'(md);
	assign n32 = 32'(mc) <<< 11;

	bsc_div u_div_t (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (v_s2),
		.num    (nmag_s2),
		.den    (dmag_s2),
		.out_vld(dv1),
		.quo    (dq1)
	);

	tline_t tdl [DIV_LAT];
	tline_t tl;
	assign tl = tdl[DIV_LAT-1];

	// Stage 3: b5, temperature, b6.
	logic signed [31:0] x2t, b5, tq;
	logic signed [15:0] tsat;
	logic signed [31:0] b6_s3;
	logic signed [15:0] temp_s3;
	logic               dz_s3;
	logic [18:0]        up_s3;
	always_comb begin
		x2t = tl.neg ? -signed'(dq1) : signed'(dq1);
		b5  = tl.x1 + x2t;
		tq  = tdiv(b5 + 32'sd8, 5'd4);
		if (tq > 32'sd32767) tsat = 16'sh7FFF;
		else if (tq < -32'sd32768) tsat = 16'sh8000;
		else tsat = tq[15:0];
	end

	// Stage 4: b6 squared, ac2 * b6, ac3 * b6.
	logic signed [63:0] sqm;
	logic signed [47:0] m2, m3;
	logic signed [31:0] sqm_s4, m2_s4, m3_s4;
	logic signed [15:0] temp_s4;
	logic               dz_s4;
	logic [18:0]        up_s4;
	assign sqm = 64'(b6_s3) * 64'(b6_s3);
	assign m2  = 48'(ac2) * 48'(b6_s3);
	assign m3  = 48'(ac3) * 48'(b6_s3);

	// Stage 5: scaling.
	logic signed [31:0] sq_s5, x2a_s5, x1c_s5;
	logic signed [15:0] temp_s5;
	logic               dz_s5;
	logic [18:0]        up_s5;

	// Stage 6: b2 * sq, b1 * sq.
	logic signed [47:0] mb2, mb1;
	logic signed [31:0] mb2_s6, mb1_s6, x2a_s6, x1c_s6;
	logic signed [15:0] temp_s6;
	logic               dz_s6;
	logic [18:0]        up_s6;
	assign mb2 = 48'(b2) * 48'(sq_s5);
	assign mb1 = 48'(b1) * 48'(sq_s5);

	// Stage 7: partial sums.
	logic signed [31:0] x3_s7, sb_s7;
	logic signed [15:0] temp_s7;
	logic               dz_s7;
	logic [18:0]        up_s7;

	// Stage 8: b3 and the b4 multiplicand.
	logic signed [31:0] bsum, bsh, b3v, x3b;
	logic [31:0]        b3_s8, xb_s8;
	logic signed [15:0] temp_s8;
	logic               dz_s8;
	logic [18:0]        up_s8;
	assign bsum = (32'(ac1) <<< 2) + x3_s7;
	assign bsh  = bsum <<< oss_q;
	assign b3v  = tdiv(bsh + 32'sd2, 5'd2);
	assign x3b  = tdiv(sb_s7 + 32'sd2, 5'd2);

	// Stage 9: b4 and up - b3.
	// The product wraps to 32 bits before the shift, so b4 keeps only 17 bits.
	logic [31:0]        pb4;
	logic [31:0]        b4_s9, diff_s9;
	logic signed [15:0] temp_s9;
	logic               dz_s9;
	assign pb4 = 32'(ac4) * xb_s8;

	// Stage 10: b7.
	logic [15:0]        coef;
	logic [47:0]        pb7;
	logic [31:0]        b4_s10, b7_s10, num2;
	logic signed [15:0] temp_s10;
	logic               err_s10;
	assign coef = P_SCALE >> oss_q;
	assign pb7  = 48'(diff_s9) * 48'(coef);
	// Small b7 is doubled before the divide, large b7 has its quotient doubled.
	assign num2 = b7_s10[31] ? b7_s10 : {b7_s10[30:0], 1'b0};

	bsc_div u_div_p (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (v_s10),
		.num    (num2),
		.den    (b4_s10),
		.out_vld(dv2),
		.quo    (dq2)
	);

	pline_t pdl [DIV_LAT];
	pline_t pl;
	assign pl = pdl[DIV_LAT-1];

	// Stage 11: raw pressure estimate.
	logic signed [31:0] presq;
	logic signed [31:0] pres_s11, a_s11;
	logic signed [15:0] temp_s11;
	logic               err_s11;
	assign presq = pl.pre ? signed'(dq2) : signed'({dq2[30:0], 1'b0});

	// Stage 12: correction products.
	logic signed [63:0] am;
	logic signed [47:0] bm;
	logic signed [31:0] x1m_s12, x2m_s12, pres_s12;
	logic signed [15:0] temp_s12;
	logic               err_s12;
	assign am = 64'(a_s11) * 64'(a_s11);
	assign bm = 48'(P_COEF_B) * 48'(pres_s11);

	// Stage 13: square term times coefficient.
	logic signed [47:0] cm;
	logic signed [31:0] m_s13, x2_s13, pres_s13;
	logic signed [15:0] temp_s13;
	logic               err_s13;
	assign cm = 48'(P_COEF_A) * 48'(x1m_s12);

	// Stage 14: correction sum.
	logic signed [31:0] s_s14, pres_s14;
	logic signed [15:0] temp_s14;
	logic               err_s14;

	// Output stage.
	logic signed [31:0] pf;
	logic [19:0]        psat;
	always_comb begin
		pf = pres_s14 + tdiv(s_s14, 5'd4);
		if (pf[31]) psat = '0;
		else if (pf > 32'sd1048575) psat = 20'hFFFFF;
		else psat = pf[19:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			v_s13 <= 1'b0; v_s14 <= 1'b0; out_valid <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++) begin
				tdl[k] <= '0;
				pdl[k] <= '0;
			end
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= dv1;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= dv2;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			out_valid <= v_s14;
			tdl[0] <= '{vld: v_s2, x1: x1_s2, neg: neg_s2, dz: dz_s2, up: up_s2};
			pdl[0] <= '{vld: v_s10, temp: temp_s10, err: err_s10, pre: !b7_s10[31]};
			for (int k = 1; k < DIV_LAT; k++) begin
				tdl[k] <= tdl[k-1];
				pdl[k] <= pdl[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1 <= p1[31:0];
			up_s1 <= raw_pressure;

			x1_s2   <= x1t;
			nmag_s2 <= n32[31] ? unsigned'(-n32) : unsigned'(n32);
			dmag_s2 <= dt[31] ? unsigned'(-dt) : unsigned'(dt);
			neg_s2  <= n32[31] ^ dt[31];
			dz_s2   <= (dt == 32'sd0);
			up_s2   <= up_s1;

			b6_s3   <= b5 - T_OFFSET;
			temp_s3 <= tsat;
			dz_s3   <= tl.dz;
			up_s3   <= tl.up;

			sqm_s4  <= sqm[31:0];
			m2_s4   <= m2[31:0];
			m3_s4   <= m3[31:0];
			temp_s4 <= temp_s3;
			dz_s4   <= dz_s3;
			up_s4   <= up_s3;

			sq_s5   <= tdiv(sqm_s4, 5'd12);
			x2a_s5  <= tdiv(m2_s4, 5'd11);
			x1c_s5  <= tdiv(m3_s4, 5'd13);
			temp_s5 <= temp_s4;
			dz_s5   <= dz_s4;
			up_s5   <= up_s4;

			mb2_s6  <= mb2[31:0];
			mb1_s6  <= mb1[31:0];
			x2a_s6  <= x2a_s5;
			x1c_s6  <= x1c_s5;
			temp_s6 <= temp_s5;
			dz_s6   <= dz_s5;
			up_s6   <= up_s5;

			x3_s7   <= tdiv(mb2_s6, 5'd11) + x2a_s6;
			sb_s7   <= x1c_s6 + tdiv(mb1_s6, 5'd16);
			temp_s7 <= temp_s6;
			dz_s7   <= dz_s6;
			up_s7   <= up_s6;

			b3_s8   <= unsigned'(b3v);
			xb_s8   <= unsigned'(x3b + X_OFFSET);
			temp_s8 <= temp_s7;
			dz_s8   <= dz_s7;
			up_s8   <= up_s7;

			b4_s9   <= {15'd0, pb4[31:15]};
			diff_s9 <= 32'(up_s8) - b3_s8;
			temp_s9 <= temp_s8;
			dz_s9   <= dz_s8;

			b4_s10   <= b4_s9;
			b7_s10   <= pb7[31:0];
			temp_s10 <= temp_s9;
			err_s10  <= dz_s9 || (b4_s9 == 32'd0);

			pres_s11 <= presq;
			a_s11    <= tdiv(presq, 5'd8);
			temp_s11 <= pl.temp;
			err_s11  <= pl.err;

			x1m_s12  <= am[31:0];
			x2m_s12  <= bm[31:0];
			pres_s12 <= pres_s11;
			temp_s12 <= temp_s11;
			err_s12  <= err_s11;

			m_s13    <= cm[31:0];
			x2_s13   <= tdiv(x2m_s12, 5'd16);
			pres_s13 <= pres_s12;
			temp_s13 <= temp_s12;
			err_s13  <= err_s12;

			s_s14    <= tdiv(m_s13, 5'd16) + x2_s13 + P_COEF_C;
			pres_s14 <= pres_s13;
			temp_s14 <= temp_s13;
			err_s14  <= err_s13;

			temperature_tenths <= err_s14 ? 16'sd0 : temp_s14;
			pressure_pa        <= err_s14 ? 20'd0 : psat;
			divide_error       <= err_s14;
		end
	end

	// The sideband lines must stay in step with the dividers.
	`BSC_ASSERT(a_tdiv_align, dv1 == tl.vld)
	`BSC_ASSERT(a_pdiv_align, dv2 == pl.vld)
	`BSC_ASSERT(a_err_zero, !(out_valid && divide_error) ||
		(temperature_tenths == 16'sd0 && pressure_pa == 20'd0))
	`BSC_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(pressure_pa))

endmodule

`default_nettype wire
